// ===== rtl/core/ltfs_pkg.sv =====
// Package for the lower-triangular forward solver: request codes, queue entry type,
// back-end state encoding and fixed-point helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ltfs_pkg;
    localparam int MAX_DIM_DEF = 16;
    localparam int DATA_W = 32;
    localparam int CFG_W = 5;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        REQ_LOAD_MAT = 2'd0,
        REQ_LOAD_RHS = 2'd1,
        REQ_SOLVE    = 2'd2,
        REQ_NONE     = 2'd3
    } req_t;

    typedef struct packed {
        req_t        kind;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [31:0] value;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIAG,
        ST_DIV,
        ST_ELIM_RD,
        ST_ELIM_MUL,
        ST_ELIM_WR
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        begin
            if (v > 66'sh0_7FFF_FFFF)
                r = 32'sh7FFF_FFFF;
            else if (v < -66'sh0_8000_0000)
                r = 32'sh8000_0000;
            else
                r = v[31:0];
            return r;
        end
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/ltfs_front.sv =====
// Front end of the forward solver: takes items, classifies and range-checks them,
// and pushes them into a two-entry queue. Depends on ltfs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ltfs_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire logic [1:0]    req_type,
    input  wire logic [3:0]    row_index,
    input  wire logic [3:0]    col_index,
    input  wire logic [31:0]   load_value,
    input  wire logic          pop,
    output logic               q_valid,
    output ltfs_pkg::cmd_t     q_head
);
    localparam int MAX_DIM = ltfs_pkg::MAX_DIM_DEF;

    ltfs_pkg::cmd_t q_reg [ltfs_pkg::QUEUE_DEPTH];
    logic [1:0] cnt_reg, cnt_next;
    logic push;
    ltfs_pkg::cmd_t cmd;
    logic keep;

    always_comb
    begin
        cmd.kind  = ltfs_pkg::req_t'(req_type);
        cmd.row   = row_index;
        cmd.col   = col_index;
        cmd.value = load_value;
        case (cmd.kind)
            ltfs_pkg::REQ_LOAD_MAT: keep = (32'(row_index) < MAX_DIM)
                                        && (32'(col_index) < MAX_DIM);
            ltfs_pkg::REQ_LOAD_RHS: keep = 32'(row_index) < MAX_DIM;
            ltfs_pkg::REQ_SOLVE:    keep = 1'b1;
            default:                keep = 1'b0;
        endcase
    end

    assign busy    = (cnt_reg == 2'(ltfs_pkg::QUEUE_DEPTH));
    assign push    = start && !busy && keep;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_head  = q_reg[0];

    always_comb
    begin
        cnt_next = cnt_reg + 2'(push) - 2'(pop && q_valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop && q_valid)
        begin
            q_reg[0] <= (push && cnt_reg == 2'd1) ? cmd : q_reg[1];
            if (push && cnt_reg == 2'd2)
                q_reg[1] <= cmd;
        end
        else if (push)
        begin
            q_reg[cnt_reg[0]] <= cmd;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/ltfs_divider.sv =====
// Iterative restoring divider for the Q16.16 quotient (w * 2^16) / L, one bit per cycle,
// truncated toward zero and saturated. Depends on ltfs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ltfs_divider (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               go,
    input  wire logic signed [31:0] num,
    input  wire logic signed [31:0] den,
    output logic                    done,
    output logic signed [31:0]      quot
);
    logic [47:0] rem_reg, rem_next;
    logic [47:0] q_reg, q_next;
    logic [31:0] d_reg;
    logic        neg_reg;
    logic [5:0]  cnt_reg;
    logic        run_reg;
    logic [48:0] trial;
    logic [47:0] mag_num;
    logic signed [65:0] signed_q;

    assign mag_num = num[31] ? 48'(-{{16{num[31]}}, num, 16'd0}) : {num, 16'd0};

    always_comb
    begin
        trial    = {rem_reg, q_reg[47]} - {17'd0, d_reg};
        rem_next = trial[48] ? {rem_reg[46:0], q_reg[47]} : trial[47:0];
        q_next   = {q_reg[46:0], ~trial[48]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= 6'd0;
            done    <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 6'd0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd47)
                begin
                    run_reg <= 1'b0;
                    done    <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rem_reg <= 48'd0;
            q_reg   <= mag_num;
            d_reg   <= den[31] ? 32'(-den) : den;
            neg_reg <= num[31] ^ den[31];
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign signed_q = neg_reg ? -$signed({18'd0, q_reg}) : $signed({18'd0, q_reg});
    assign quot     = ltfs_pkg::sat32(signed_q);
endmodule
`default_nettype wire

// ===== rtl/core/ltfs_back.sv =====
// Back end of the forward solver: holds matrix and right-hand-side stores, executes
// loads and runs the column-by-column elimination. Depends on ltfs_pkg, ltfs_divider.
`timescale 1ns / 1ps
`default_nettype none
module ltfs_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [4:0]         size,
    input  wire logic               q_valid,
    input  wire ltfs_pkg::cmd_t     q_head,
    output logic                    pop,
    output logic                    sol_valid,
    output logic [3:0]              sol_index,
    output logic [31:0]             sol_value,
    output logic                    zero_pivot,
    output logic                    last_of_run
);
    localparam int MAX_DIM = ltfs_pkg::MAX_DIM_DEF;
    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int AW = 2 * IW;

    logic [31:0] mat_mem [MAX_DIM * MAX_DIM];
    logic [MAX_DIM*MAX_DIM-1:0] mat_ok_reg;
    logic [31:0] rhs_reg [MAX_DIM];
    logic [31:0] w_reg [MAX_DIM];

    ltfs_pkg::state_t state_reg, state_next;
    logic [IW:0] n_reg;
    logic [IW-1:0] i_reg, k_reg;
    logic [31:0] rd_reg;
    logic        rd_ok_reg;
    logic signed [31:0] x_reg;
    logic signed [63:0] prod_reg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic        div_go, div_done;
    logic signed [31:0] div_q;
    logic signed [31:0] lval;
    logic [IW:0] n_eff;
    logic        do_load_mat;
    logic signed [65:0] prod_q;
    logic signed [65:0] diff;

    assign n_eff = (size == 5'd0) ? (IW+1)'(1)
                 : (32'(size) > MAX_DIM) ? (IW+1)'(MAX_DIM) : (IW+1)'(size);
    assign wr_addr = {q_head.row[IW-1:0], q_head.col[IW-1:0]};
    assign lval = rd_ok_reg ? $signed(rd_reg) : 32'sd0;

    ltfs_divider u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (div_go),
        .num  ($signed(w_reg[i_reg])),
        .den  (lval),
        .done (div_done),
        .quot (div_q)
    );

    always_comb
    begin
        state_next  = state_reg;
        pop         = 1'b0;
        div_go      = 1'b0;
        do_load_mat = 1'b0;
        rd_addr     = {i_reg, i_reg};
        case (state_reg)
            ltfs_pkg::ST_IDLE:
            begin
                rd_addr = '0;
                if (q_valid)
                begin
                    pop = 1'b1;
                    if (q_head.kind == ltfs_pkg::REQ_SOLVE)
                        state_next = ltfs_pkg::ST_DIAG;
                    else if (q_head.kind == ltfs_pkg::REQ_LOAD_MAT)
                        do_load_mat = 1'b1;
                end
            end
            ltfs_pkg::ST_DIAG:
            begin
                state_next = ltfs_pkg::ST_DIV;
                div_go     = (lval != 32'sd0);
            end
            ltfs_pkg::ST_DIV:
            begin
                if (lval == 32'sd0 || div_done)
                    state_next = ((IW+1)'(i_reg) + 1'b1 == n_reg) ? ltfs_pkg::ST_IDLE
                                                                    : ltfs_pkg::ST_ELIM_RD;
            end
            ltfs_pkg::ST_ELIM_RD:
            begin
                rd_addr    = {k_reg, i_reg};
                state_next = ltfs_pkg::ST_ELIM_MUL;
            end
            ltfs_pkg::ST_ELIM_MUL:
                state_next = ltfs_pkg::ST_ELIM_WR;
            ltfs_pkg::ST_ELIM_WR:
            begin
                if ((IW+1)'(k_reg) + 1'b1 == n_reg)
                    state_next = ltfs_pkg::ST_DIAG;
                else
                    state_next = ltfs_pkg::ST_ELIM_RD;
                rd_addr = {(IW)'(i_reg + 1'b1), (IW)'(i_reg + 1'b1)};
            end
            default:
                state_next = ltfs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_load_mat)
            mat_mem[wr_addr] <= q_head.value;
        rd_reg <= mat_mem[rd_addr];
    end

    assign prod_q = $signed({{2{prod_reg[63]}}, prod_reg}) >>> 16;
    assign diff   = $signed({{34{w_reg[k_reg][31]}}, w_reg[k_reg]})
                  - $signed(66'(ltfs_pkg::sat32(prod_q)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ltfs_pkg::ST_IDLE;
            mat_ok_reg <= '0;
            rd_ok_reg  <= 1'b0;
            sol_valid  <= 1'b0;
            for (int r = 0; r < MAX_DIM; r++)
                rhs_reg[r] <= 32'd0;
        end
        else
        begin
            state_reg <= state_next;
            sol_valid <= 1'b0;
            rd_ok_reg <= mat_ok_reg[rd_addr] || (do_load_mat && wr_addr == rd_addr);
            if (do_load_mat)
                mat_ok_reg[wr_addr] <= 1'b1;
            if (state_reg == ltfs_pkg::ST_IDLE && q_valid
                && q_head.kind == ltfs_pkg::REQ_LOAD_RHS)
                rhs_reg[q_head.row[IW-1:0]] <= q_head.value;
            if (state_reg == ltfs_pkg::ST_DIV && (lval == 32'sd0 || div_done))
                sol_valid <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ltfs_pkg::ST_IDLE:
            begin
                i_reg <= '0;
                n_reg <= n_eff;
                for (int r = 0; r < MAX_DIM; r++)
                    w_reg[r] <= rhs_reg[r];
            end
            ltfs_pkg::ST_DIV:
            begin
                k_reg <= (IW)'(i_reg + 1'b1);
                if (lval == 32'sd0)
                begin
                    x_reg      <= w_reg[i_reg][31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    sol_value  <= w_reg[i_reg][31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    zero_pivot <= 1'b1;
                end
                else
                begin
                    x_reg      <= div_q;
                    sol_value  <= div_q;
                    zero_pivot <= 1'b0;
                end
                sol_index   <= 4'(i_reg);
                last_of_run <= ((IW+1)'(i_reg) + 1'b1 == n_reg);
            end
            ltfs_pkg::ST_ELIM_MUL:
                prod_reg <= 64'(x_reg) * 64'(lval);
            ltfs_pkg::ST_ELIM_WR:
            begin
                w_reg[k_reg] <= ltfs_pkg::sat32(diff);
                k_reg        <= (IW)'(k_reg + 1'b1);
                if ((IW+1)'(k_reg) + 1'b1 == n_reg)
                    i_reg <= (IW)'(i_reg + 1'b1);
            end
            default:
            begin
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/core/lower_triangular_forward_solve.sv =====
// Top level of the lower-triangular forward solver: configuration register,
// front end with command queue and back end. Depends on ltfs_pkg, ltfs_front, ltfs_back.
//
// Usage: drive an item with start high; it is taken at an edge where busy is low.
// req_type 0 loads matrix entry (row_index, col_index), 1 loads a right-hand-side
// entry, 2 runs a solve of order matrix_size; code 3 and out-of-range loads are dropped.
// The matrix_size register is written over cfg_valid/cfg_ready/cfg_data; cfg_ready
// is always high, write only while no solve is in flight.
// Loads are taken one per cycle while busy is low and executed by the back end one per
// cycle while it is idle, behind a two-entry queue. A solve emits n results on sol_valid,
// one cycle each, index 0 first, last_of_run on the final one. Per element: a pivot-read
// state, then the bit-serial divider (skipped for a zero pivot), then a read, a multiply
// and a write-back state per eliminated row. While a solve runs the queue fills and
// busy rises after two more items. Results cannot be stalled by the receiver.
// Reset clears both stores (valid bits for the matrix), empties the queue and sets
// matrix_size to 16.
`timescale 1ns / 1ps
`default_nettype none
module lower_triangular_forward_solve (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  req_type,
    input  wire logic [3:0]  row_index,
    input  wire logic [3:0]  col_index,
    input  wire logic [31:0] load_value,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [4:0]  cfg_data,
    output logic             sol_valid,
    output logic [3:0]       sol_index,
    output logic [31:0]      sol_value,
    output logic             zero_pivot,
    output logic             last_of_run
);
    logic [4:0] size_reg;
    logic pop, q_valid;
    ltfs_pkg::cmd_t q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= 5'd16;
        else if (cfg_valid)
            size_reg <= cfg_data;
    end

    ltfs_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .row_index(row_index), .col_index(col_index),
        .load_value(load_value), .pop(pop), .q_valid(q_valid), .q_head(q_head)
    );

    ltfs_back u_back (
        .clk(clk), .rst_n(rst_n), .size(size_reg), .q_valid(q_valid), .q_head(q_head),
        .pop(pop), .sol_valid(sol_valid), .sol_index(sol_index), .sol_value(sol_value),
        .zero_pivot(zero_pivot), .last_of_run(last_of_run)
    );
endmodule
`default_nettype wire

// ===== rtl/core/ltfs_checker.sv =====
// Port-level checker for the forward solver, bound to the top level.
// Depends on lower_triangular_forward_solve ports only.
`timescale 1ns / 1ps
`default_nettype none
module ltfs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        busy,
    input wire logic        sol_valid,
    input wire logic [3:0]  sol_index,
    input wire logic        last_of_run
);
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        sol_valid |=> !sol_valid) else $error("results on adjacent cycles");
    a_first_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (sol_valid && last_of_run) |=> !sol_valid) else $error("bad run end");
    a_busy_reset: assert property (@(posedge clk)
        !rst_n |-> !busy) else $error("busy in reset");
    a_last_is_top: assert property (@(posedge clk) disable iff (!rst_n)
        (sol_valid && sol_index == 4'd15) |-> last_of_run) else $error("missing last");
endmodule

bind lower_triangular_forward_solve ltfs_checker u_chk (
    .clk(clk), .rst_n(rst_n), .busy(busy), .sol_valid(sol_valid),
    .sol_index(sol_index), .last_of_run(last_of_run)
);
`default_nettype wire

// ===== tb/sv/tb_lower_triangular_forward_solve.sv =====
// Testbench for lower_triangular_forward_solve: loads matrix and right-hand-side items,
// runs solves at several orders and checks every solution element against a local model.
// Depends on ltfs_pkg and the RTL of the solver.
`timescale 1ns / 1ps
module tb_lower_triangular_forward_solve;
    typedef struct {
        logic [3:0]  index;
        logic [31:0] value;
        logic        zp;
        logic        last;
    } sol_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  req_type;
    logic [3:0]  row_index;
    logic [3:0]  col_index;
    logic [31:0] load_value;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [4:0]  cfg_data;
    logic        sol_valid;
    logic [3:0]  sol_index;
    logic [31:0] sol_value;
    logic        zero_pivot;
    logic        last_of_run;

    logic signed [31:0] lmat [0:15][0:15];
    logic signed [31:0] rhs [0:15];
    logic [4:0]  order_reg;
    sol_t        pending_sols [$];
    int          errors;
    bit          no_idle;

    lower_triangular_forward_solve DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .row_index(row_index), .col_index(col_index),
        .load_value(load_value), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_data(cfg_data), .sol_valid(sol_valid), .sol_index(sol_index),
        .sol_value(sol_value), .zero_pivot(zero_pivot), .last_of_run(last_of_run)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic signed [31:0] clamp32(input logic signed [65:0] v);
        if (v > 66'sh7FFFFFFF)
            return 32'sh7FFFFFFF;
        if (v < -66'sh80000000)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [65:0] p;
        p = 66'(a) * 66'(b);
        return clamp32(p >>> 16);
    endfunction

    task automatic predict_solve();
        logic signed [31:0] w [0:15];
        logic signed [31:0] x;
        logic signed [65:0] q;
        sol_t s;
        int n;
        n = (order_reg == 0) ? 1 : (order_reg > 16 ? 16 : order_reg);
        for (int i = 0; i < 16; i++)
            w[i] = rhs[i];
        for (int i = 0; i < n; i++)
        begin
            s.zp = (lmat[i][i] == 0);
            if (s.zp)
                x = (w[i] >= 0) ? 32'sh7FFFFFFF : 32'sh80000000;
            else
            begin
                q = (66'(w[i]) <<< 16) / 66'(lmat[i][i]);
                x = clamp32(q);
            end
            for (int k = i + 1; k < n; k++)
                w[k] = clamp32(66'(w[k]) - 66'(fx_mul(x, lmat[k][i])));
            s.index = i[3:0];
            s.value = x;
            s.last = (i == n - 1);
            pending_sols.push_back(s);
        end
    endtask

    task automatic send_item(input ltfs_pkg::req_t kind, input logic [3:0] r,
                             input logic [3:0] c, input logic [31:0] v);
        while (!no_idle && $urandom_range(99) < 32)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req_type <= kind;
        row_index <= r;
        col_index <= c;
        load_value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        case (kind)
            ltfs_pkg::REQ_LOAD_MAT: lmat[r][c] = v;
            ltfs_pkg::REQ_LOAD_RHS: rhs[r] = v;
            ltfs_pkg::REQ_SOLVE:    predict_solve();
            default: ;
        endcase
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_sols.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_order(input logic [4:0] n);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= n;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        order_reg = n;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'h00010000 * $urandom_range(1, 4);
            3: return -32'sh00010000 * $urandom_range(1, 4);
            4: return 32'(signed'($urandom_range(65535)) - 32768) <<< $urandom_range(4, 18);
            default: return $urandom;
        endcase
    endfunction

    task automatic load_system(input int n, input bit zeros);
        for (int r = 0; r < n; r++)
        begin
            for (int c = 0; c <= r; c++)
                send_item(ltfs_pkg::REQ_LOAD_MAT, 4'(r), 4'(c),
                          (c == r && !(zeros && $urandom_range(3) == 0)) ?
                          32'h00010000 * $urandom_range(1, 8) + $urandom_range(65535)
                          : rand_value());
            send_item(ltfs_pkg::REQ_LOAD_RHS, 4'(r), 4'd0, rand_value());
        end
    endtask

    task automatic test_directed();
        send_item(ltfs_pkg::REQ_SOLVE, 4'd0, 4'd0, 32'd0);
        send_item(ltfs_pkg::REQ_LOAD_MAT, 4'd0, 4'd0, 32'h00010000);
        send_item(ltfs_pkg::REQ_LOAD_MAT, 4'd15, 4'd15, 32'h80000000);
        send_item(ltfs_pkg::REQ_LOAD_MAT, 4'd15, 4'd0, 32'h7FFFFFFF);
        send_item(ltfs_pkg::REQ_LOAD_MAT, 4'd1, 4'd1, 32'hFFFFFFFF);
        send_item(ltfs_pkg::REQ_LOAD_MAT, 4'd2, 4'd0, 32'h00000001);
        send_item(ltfs_pkg::REQ_LOAD_MAT, 4'd0, 4'd15, 32'h12345678);
        send_item(ltfs_pkg::REQ_LOAD_RHS, 4'd0, 4'hF, 32'h7FFFFFFF);
        send_item(ltfs_pkg::REQ_LOAD_RHS, 4'd15, 4'd0, 32'h80000000);
        send_item(ltfs_pkg::REQ_LOAD_RHS, 4'd1, 4'd0, 32'h80000000);
        send_item(ltfs_pkg::REQ_NONE, 4'hF, 4'hF, 32'hFFFFFFFF);
        send_item(ltfs_pkg::REQ_SOLVE, 4'hF, 4'hF, 32'hFFFFFFFF);
        send_item(ltfs_pkg::REQ_SOLVE, 4'd0, 4'd0, 32'd0);
    endtask

    task automatic test_orders();
        write_order(5'd0);
        send_item(ltfs_pkg::REQ_SOLVE, 4'd0, 4'd0, 32'd0);
        write_order(5'd31);
        send_item(ltfs_pkg::REQ_SOLVE, 4'd0, 4'd0, 32'd0);
        write_order(5'd17);
        send_item(ltfs_pkg::REQ_SOLVE, 4'd0, 4'd0, 32'd0);
        write_order(5'd1);
        send_item(ltfs_pkg::REQ_SOLVE, 4'd0, 4'd0, 32'd0);
    endtask

    task automatic test_random();
        int n;
        for (int t = 0; t < 6; t++)
        begin
            n = (t == 4) ? 16 : $urandom_range(1, 5);
            write_order(n[4:0]);
            no_idle = (t == 4);
            load_system(n, 1'(t % 2));
            send_item(ltfs_pkg::REQ_SOLVE, 4'($urandom), 4'($urandom), $urandom);
            if ($urandom_range(1))
                send_item(ltfs_pkg::REQ_SOLVE, 4'd0, 4'd0, 32'd0);
            send_item(ltfs_pkg::req_t'($urandom_range(3)), 4'($urandom), 4'($urandom),
                      $urandom);
            if (t == 2)
                drain();
        end
        no_idle = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && sol_valid)
        begin
            if (pending_sols.size() == 0)
            begin
                $error("unexpected result index %0d", sol_index);
                errors++;
            end
            else
            begin
                sol_t e;
                e = pending_sols.pop_front();
                if (sol_index !== e.index)
                begin
                    $error("sol_index expected %0d actual %0d", e.index, sol_index);
                    errors++;
                end
                if (sol_value !== e.value)
                begin
                    $error("sol_value expected %h actual %h", e.value, sol_value);
                    errors++;
                end
                if (zero_pivot !== e.zp)
                begin
                    $error("zero_pivot expected %b actual %b", e.zp, zero_pivot);
                    errors++;
                end
                if (last_of_run !== e.last)
                begin
                    $error("last_of_run expected %b actual %b", e.last, last_of_run);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        errors = 0;
        no_idle = 1'b0;
        order_reg = 5'd16;
        for (int r = 0; r < 16; r++)
        begin
            rhs[r] = 0;
            for (int c = 0; c < 16; c++)
                lmat[r][c] = 0;
        end
        rst_n = 1'b1;
        start = 1'b0;
        req_type = ltfs_pkg::REQ_NONE;
        row_index = 4'd0;
        col_index = 4'd0;
        load_value = 32'd0;
        cfg_valid = 1'b0;
        cfg_data = 5'd0;
        #1;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_orders();
        test_random();
        drain();
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/core/ltfs_pkg.sv
rtl/core/ltfs_front.sv
rtl/core/ltfs_divider.sv
rtl/core/ltfs_back.sv
rtl/core/lower_triangular_forward_solve.sv
rtl/core/ltfs_checker.sv
tb/sv/tb_lower_triangular_forward_solve.sv
